>>> rtl/core/tlca_pkg.sv
// ----------------------------------------------------------------------------
// tlca_pkg
// Codes and field widths shared by the lowest common ancestor block.
// ----------------------------------------------------------------------------
package tlca_pkg;

	localparam int FIELD_W = 10;
	localparam int DEPTH_W = 10;
	localparam int CFG_W   = 11;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_BUILD = 2'd1,
		KIND_LCA   = 2'd2,
		KIND_ANC   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		RK_BUILD = 2'd0,
		RK_LCA   = 2'd1,
		RK_ANC   = 2'd2
	} res_kind_t;

endpackage

>>> rtl/core/tree_lca_binary_lifting_top.sv
// Load: one write to the table and the depth store. Build: per node and level
//   pass, a read of the entry, then a write of none, or a second read and a write
//   of the fetched entry; LEVELS-1 passes over min(node_count, MAX_NODES) nodes.
// LCA query: depth reads, lift of the deeper node, descent from the top level and
//   a final parent read; ancestor query walks levels down; one table read per step.
// A new word is taken only when the sequencer is idle.
// arst_n clears control state; table and depth store are undefined until loaded.
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_top
// Binary lifting LCA and k-th ancestor engine on a shared table read port.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting_top
	import tlca_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS = 11
) (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: node[9:0], other_node[19:10], parent_node[29:20], parent_is_none[30],
	//        node_depth_in[40:31], step_count[50:41], zero fill
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // answer_node[9:0], answer_none[10], zero fill
	output logic [1:0]  m_tuser,  // result_kind[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data  // node_count
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int LW = $clog2(LEVELS);
	localparam int KW = $clog2(LEVELS + 1);
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = LEVELS;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001, ST_B1 = 17'h00002, ST_B2 = 17'h00004, ST_B3 = 17'h00008,
		ST_LD0 = 17'h00010, ST_LD1 = 17'h00020, ST_LD2 = 17'h00040, ST_LU = 17'h00080,
		ST_LW = 17'h00100, ST_D1 = 17'h00200, ST_D2 = 17'h00400, ST_D3 = 17'h00800,
		ST_F1 = 17'h01000, ST_F2 = 17'h02000, ST_AU = 17'h04000, ST_AW = 17'h08000,
		ST_DONE = 17'h10000
	} state_t;

	state_t state_q;
	logic [CFG_W-1:0]   node_count_q;
	logic [CW-1:0]      count_q;
	logic [KW-1:0]      k_q;
	logic [NW-1:0]      u_q, v_q;
	logic [NW:0]        eu_q;
	logic [DEPTH_W-1:0] du_q;
	logic [SW-1:0]      bits_q;
	logic [1:0]         res_kind_q;
	logic [FIELD_W-1:0] res_node_q;
	logic               res_none_q;
	logic               out_v_q;
	logic [1:0]         out_kind_q;
	logic [FIELD_W-1:0] out_node_q;
	logic               out_none_q;

	logic [FIELD_W-1:0] f_node, f_other, f_par, f_dep, f_step;
	logic               f_pnone, accept, node_ok, other_ok, par_ok;
	logic               t_we, d_we;
	logic [LW+NW-1:0]   t_waddr, t_raddr;
	logic [NW:0]        t_wdata, t_rdata;
	logic [NW-1:0]      d_raddr;
	logic [DEPTH_W-1:0] d_rdata;
	logic [LW-1:0]      kl, kl_next;
	logic               r_none;
	logic [NW-1:0]      r_idx;
	logic [DEPTH_W-1:0] diff;

	assign f_node  = s_tdata[9:0];
	assign f_other = s_tdata[19:10];
	assign f_par   = s_tdata[29:20];
	assign f_pnone = s_tdata[30];
	assign f_dep   = s_tdata[40:31];
	assign f_step  = s_tdata[50:41];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign node_ok  = (32'(f_node) < MAX_NODES);
	assign other_ok = (32'(f_other) < MAX_NODES);
	assign par_ok   = (32'(f_par) < MAX_NODES) && !f_pnone;

	assign kl      = k_q[LW-1:0];
	assign kl_next = LW'(k_q + 1'b1);
	assign r_none  = t_rdata[NW];
	assign r_idx   = t_rdata[NW-1:0];
	assign diff    = (du_q > d_rdata) ? (du_q - d_rdata) : (d_rdata - du_q);

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {5'd0, out_none_q, out_node_q};

	tlca_mem #(.NW(NW), .LW(LW), .LEVELS(LEVELS)) u_mem (
		.clk(clk),
		.t_we(t_we), .t_waddr(t_waddr), .t_wdata(t_wdata),
		.t_raddr(t_raddr), .t_rdata(t_rdata),
		.d_we(d_we), .d_waddr(NW'(f_node)), .d_wdata(f_dep),
		.d_raddr(d_raddr), .d_rdata(d_rdata)
	);

	// table port steering
	always_comb begin
		t_we    = 1'b0;
		t_waddr = {kl_next, u_q};
		t_wdata = {1'b1, NW'(0)};
		t_raddr = {kl, v_q};
		d_we    = 1'b0;
		d_raddr = (state_q == ST_LD0) ? u_q : v_q;
		case (state_q)
			ST_IDLE: begin
				t_we    = accept && (s_tuser == KIND_LOAD) && node_ok;
				d_we    = t_we;
				t_waddr = {LW'(0), NW'(f_node)};
				t_wdata = par_ok ? {1'b0, NW'(f_par)} : {1'b1, NW'(0)};
			end
			ST_B1: t_raddr = {kl, u_q};
			ST_B2: begin
				t_raddr = {kl, r_idx};
				t_we    = r_none;
			end
			ST_B3: begin
				t_we    = 1'b1;
				t_wdata = t_rdata;
			end
			ST_D1:   t_raddr = {kl, u_q};
			ST_F1:   t_raddr = {LW'(0), u_q};
			default: t_raddr = {kl, v_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(1024);
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && m_tready && state_q != ST_DONE) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (s_tuser)
							KIND_BUILD: begin
								res_kind_q <= RK_BUILD;
								res_node_q <= '0;
								res_none_q <= 1'b0;
								k_q <= '0;
								u_q <= '0;
								if (32'(node_count_q) > MAX_NODES) begin
									count_q <= CW'(MAX_NODES);
								end else begin
									count_q <= CW'(node_count_q);
								end
								state_q <= (node_count_q == '0) ? ST_DONE : ST_B1;
							end
							KIND_LCA: begin
								res_kind_q <= RK_LCA;
								res_node_q <= '0;
								res_none_q <= 1'b1;
								u_q <= NW'(f_node);
								v_q <= NW'(f_other);
								state_q <= (node_ok && other_ok) ? ST_LD0 : ST_DONE;
							end
							KIND_ANC: begin
								res_kind_q <= RK_ANC;
								res_node_q <= '0;
								res_none_q <= 1'b1;
								v_q <= NW'(f_node);
								bits_q <= SW'(f_step);
								k_q <= KW'(LEVELS - 1);
								state_q <= node_ok ? ST_AU : ST_DONE;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_B1: state_q <= ST_B2;
				ST_B2, ST_B3: begin
					if (state_q == ST_B2 && !r_none) begin
						state_q <= ST_B3;
					end else if (CW'(u_q) + 1'b1 == count_q) begin
						u_q <= '0;
						if (k_q == KW'(LEVELS - 2)) begin
							state_q <= ST_DONE;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= ST_B1;
						end
					end else begin
						u_q <= u_q + 1'b1;
						state_q <= ST_B1;
					end
				end
				ST_LD0: state_q <= ST_LD1;
				ST_LD1: begin
					du_q <= d_rdata;
					state_q <= ST_LD2;
				end
				ST_LD2: begin
					// keep the deeper node in v
					if (du_q > d_rdata) begin
						u_q <= v_q;
						v_q <= u_q;
					end
					bits_q <= SW'(diff);
					k_q <= '0;
					state_q <= ST_LU;
				end
				ST_LU: begin
					if (k_q == KW'(LEVELS)) begin
						if (u_q == v_q) begin
							res_node_q <= FIELD_W'(u_q);
							res_none_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							k_q <= KW'(LEVELS - 1);
							state_q <= ST_D1;
						end
					end else if (bits_q[kl]) begin
						state_q <= ST_LW;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_LW: begin
					if (r_none) begin
						state_q <= ST_DONE;
					end else begin
						v_q <= r_idx;
						k_q <= k_q + 1'b1;
						state_q <= ST_LU;
					end
				end
				ST_D1: state_q <= ST_D2;
				ST_D2: begin
					eu_q <= t_rdata;
					state_q <= ST_D3;
				end
				ST_D3: begin
					if (eu_q != t_rdata && (eu_q[NW] || r_none)) begin
						state_q <= ST_DONE;
					end else begin
						if (eu_q != t_rdata) begin
							u_q <= eu_q[NW-1:0];
							v_q <= r_idx;
						end
						if (k_q == '0) begin
							state_q <= ST_F1;
						end else begin
							k_q <= k_q - 1'b1;
							state_q <= ST_D1;
						end
					end
				end
				ST_F1: state_q <= ST_F2;
				ST_F2: begin
					if (!r_none) begin
						res_node_q <= FIELD_W'(r_idx);
						res_none_q <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_AU: begin
					if (bits_q[kl]) begin
						state_q <= ST_AW;
					end else if (k_q == '0) begin
						res_node_q <= FIELD_W'(v_q);
						res_none_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				ST_AW: begin
					if (r_none) begin
						state_q <= ST_DONE;
					end else begin
						v_q <= r_idx;
						if (k_q == '0) begin
							res_node_q <= FIELD_W'(r_idx);
							res_none_q <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							k_q <= k_q - 1'b1;
							state_q <= ST_AU;
						end
					end
				end
				ST_DONE: begin
					// hold until the output register frees up
					if (!out_v_q || m_tready) begin
						out_v_q    <= 1'b1;
						out_kind_q <= res_kind_q;
						out_node_q <= res_node_q;
						out_none_q <= res_none_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !out_v_q) |=> out_v_q)
		else $error("finished result not moved to output");
	a_build_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_B2 && !r_none) |=> (state_q == ST_B3))
		else $error("build skipped second table read");
	a_build_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_kind_q == RK_BUILD) |-> (m_tdata == 16'd0))
		else $error("build done word carries data");
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_none_q) |-> (out_node_q == '0))
		else $error("none answer with nonzero node");
`endif

endmodule

>>> rtl/core/tlca_mem.sv
// ----------------------------------------------------------------------------
// tlca_mem
// Ancestor table (level, node) and depth store, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module tlca_mem
	import tlca_pkg::*;
#(
	parameter int NW = 10,
	parameter int LW = 4,
	parameter int LEVELS = 11
) (
	input  logic                 clk,
	input  logic                 t_we,
	input  logic [LW+NW-1:0]     t_waddr,
	input  logic [NW:0]          t_wdata,
	input  logic [LW+NW-1:0]     t_raddr,
	output logic [NW:0]          t_rdata,
	input  logic                 d_we,
	input  logic [NW-1:0]        d_waddr,
	input  logic [DEPTH_W-1:0]   d_wdata,
	input  logic [NW-1:0]        d_raddr,
	output logic [DEPTH_W-1:0]   d_rdata
);

	localparam int TD = LEVELS * (2 ** NW);

	logic [NW:0]        table_q [TD];
	logic [DEPTH_W-1:0] depth_q [2 ** NW];

	always_ff @(posedge clk) begin
		if (t_we) begin
			table_q[t_waddr] <= t_wdata;
		end
		t_rdata <= table_q[t_raddr];
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			depth_q[d_waddr] <= d_wdata;
		end
		d_rdata <= depth_q[d_raddr];
	end

endmodule

>>> test/tb_tree_lca_binary_lifting_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tree_lca_binary_lifting_top
// Loads a full 1024-node tree first, so that every table entry is defined.
// Then runs a directed table and random forests under several node counts.
// Each accepted answer word is checked against a local binary lifting model or a typed directed answer.
// Stalls vary on both sides, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_tree_lca_binary_lifting_top;
	import tlca_pkg::*;

	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 11;
	localparam int STALL_LIMIT = 100000;
	localparam int RAND_ITEMS  = 450;
	localparam logic [10:0] NONE_ENTRY = 11'h400;

	typedef struct packed {
		kind_t      kind;
		logic [9:0] node;
		logic [9:0] other;
		logic [9:0] par;
		logic       pnone;
		logic [9:0] dep;
		logic [9:0] cnt;
	} tree_word_t;

	typedef struct packed {
		res_kind_t  kind;
		logic [9:0] node;
		logic       none;
	} answer_t;

	typedef struct packed {
		tree_word_t w;
		logic       typed;
		answer_t    ans;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	logic [10:0] lift_tab [LEVELS][MAX_NODES];
	logic [9:0]  depth_tab [MAX_NODES];
	logic [10:0] node_limit;
	logic [9:0]  forest_depth [MAX_NODES];

	answer_t     pending_answers [$];
	dir_row_t    dir_rows [17];
	int          errors = 0;
	int          words_sent = 0;
	int          answers_seen = 0;
	int          src_idle = 32;
	int          dst_idle = 65;
	bit          hold_req = 0;
	bit          hold_out = 0;
	int          stall_cycles = 0;

	tree_lca_binary_lifting_top #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [10:0] common_ancestor(logic [9:0] a, logic [9:0] b);
		logic [9:0]  u, v, t, diff;
		logic [10:0] eu, ev;
		u = a;
		v = b;
		if (depth_tab[u] > depth_tab[v]) begin
			t = u; u = v; v = t;
		end
		diff = depth_tab[v] - depth_tab[u];
		for (int k = 0; k < LEVELS; k++) begin
			if (k < 10 && diff[k]) begin
				ev = lift_tab[k][v];
				if (ev[10]) return NONE_ENTRY;
				v = ev[9:0];
			end
		end
		if (u == v) return {1'b0, u};
		for (int k = LEVELS - 1; k >= 0; k--) begin
			eu = lift_tab[k][u];
			ev = lift_tab[k][v];
			if (eu != ev) begin
				if (eu[10] || ev[10]) return NONE_ENTRY;
				u = eu[9:0];
				v = ev[9:0];
			end
		end
		eu = lift_tab[0][u];
		if (eu[10]) return NONE_ENTRY;
		return eu;
	endfunction

	function automatic logic [10:0] climb_up(logic [9:0] start, logic [9:0] steps);
		logic [9:0]  v;
		logic [10:0] e;
		v = start;
		for (int k = LEVELS - 1; k >= 0; k--) begin
			if (k < 10 && steps[k]) begin
				e = lift_tab[k][v];
				if (e[10]) return NONE_ENTRY;
				v = e[9:0];
			end
		end
		return {1'b0, v};
	endfunction

	// Update the tree model for one word; return 1 when it yields an answer.
	function automatic bit predict_word(tree_word_t w, output answer_t ans);
		int          span;
		logic [10:0] e;
		ans.kind = RK_BUILD;
		ans.node = '0;
		ans.none = 1'b0;
		case (w.kind)
			KIND_LOAD: begin
				lift_tab[0][w.node] = w.pnone ? NONE_ENTRY : {1'b0, w.par};
				depth_tab[w.node] = w.dep;
				return 0;
			end
			KIND_BUILD: begin
				span = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
				for (int k = 0; k + 1 < LEVELS; k++) begin
					for (int v = 0; v < span; v++) begin
						e = lift_tab[k][v];
						lift_tab[k + 1][v] = e[10] ? NONE_ENTRY : lift_tab[k][e[9:0]];
					end
				end
				return 1;
			end
			KIND_LCA: begin
				ans.kind = RK_LCA;
				e = common_ancestor(w.node, w.other);
			end
			default: begin
				ans.kind = RK_ANC;
				e = climb_up(w.node, w.cnt);
			end
		endcase
		ans.none = e[10];
		ans.node = e[10] ? 10'd0 : e[9:0];
		return 1;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	task automatic send_word(tree_word_t w, bit typed = 0, answer_t typed_ans = '0);
		answer_t ans;
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, w.cnt, w.dep, w.pnone, w.par, w.other, w.node};
		s_tuser  <= w.kind;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (predict_word(w, ans))
			pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
	endtask

	task automatic drain(int extra);
		if (s_tvalid) begin
			s_tvalid <= 1'b0;
		end
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_node_count(logic [10:0] value);
		drain(64);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_limit = value;
	endtask

	function automatic tree_word_t make_word(kind_t kind, int node, int other, int par,
						 int pnone, int dep, int cnt);
		tree_word_t w;
		w.kind = kind; w.node = 10'(node); w.other = 10'(other); w.par = 10'(par);
		w.pnone = 1'(pnone); w.dep = 10'(dep); w.cnt = 10'(cnt);
		return w;
	endfunction

	// Load a forest on nodes 0 .. span-1, mostly consistent, some broken words.
	task automatic load_forest(int span);
		int p;
		for (int i = 0; i < span; i++) begin
			if ($urandom_range(99) < 8) begin
				send_word(make_word(KIND_LOAD, i, $urandom_range(1023), $urandom_range(1023),
					$urandom_range(1), $urandom_range(1023), $urandom_range(1023)));
				forest_depth[i] = 10'd0;
			end else if (i == 0 || $urandom_range(99) < 10) begin
				send_word(make_word(KIND_LOAD, i, $urandom_range(1023), $urandom_range(1023),
					1, 0, $urandom_range(1023)));
				forest_depth[i] = 10'd0;
			end else begin
				p = $urandom_range(i - 1);
				forest_depth[i] = forest_depth[p] + 10'd1;
				send_word(make_word(KIND_LOAD, i, $urandom_range(1023), p, 0,
					forest_depth[i], $urandom_range(1023)));
			end
		end
	endtask

	// Receive side: random ready, long hold-off on request, check each word.
	initial begin
		answer_t want;
		@(posedge arst_n);
		forever begin
			m_tready <= !hold_out && ($urandom_range(99) >= dst_idle);
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				answers_seen++;
				if (pending_answers.size() == 0) begin
					report_mismatch("unexpected answer word, kind", m_tuser, -1);
				end else begin
					want = pending_answers.pop_front();
					if (m_tuser != want.kind) report_mismatch("result_kind", m_tuser, want.kind);
					if (m_tdata[9:0] != want.node)
						report_mismatch("answer_node", m_tdata[9:0], want.node);
					if (m_tdata[10] != want.none)
						report_mismatch("answer_none", m_tdata[10], want.none);
					if (m_tdata[15:11] != 5'd0) report_mismatch("tdata fill", m_tdata[15:11], 0);
				end
			end
		end
	end

	initial begin
		wait (hold_req);
		@(posedge clk);
		hold_out = 1;
		repeat (3000) @(posedge clk);
		hold_out = 0;
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int span, phase, rand_count, a;
		logic [10:0] count_sel;
		answer_t done_ans, none_ans;

		done_ans = '{RK_BUILD, 10'd0, 1'b0};
		none_ans = '{RK_ANC, 10'd0, 1'b1};
		dir_rows = '{
			'{make_word(KIND_LOAD, 1023, 0, 1023, 1, 0, 0), 1'b0, done_ans},
			'{make_word(KIND_BUILD, 0, 0, 0, 0, 0, 0), 1'b1, done_ans},
			'{make_word(KIND_ANC, 1023, 0, 0, 0, 0, 1), 1'b1, none_ans},
			'{make_word(KIND_ANC, 1023, 0, 0, 0, 0, 0), 1'b1, '{RK_ANC, 10'd1023, 1'b0}},
			'{make_word(KIND_LCA, 1023, 0, 0, 0, 0, 0), 1'b1, '{RK_LCA, 10'd0, 1'b1}},
			'{make_word(KIND_LCA, 1023, 1023, 0, 0, 0, 0), 1'b1, '{RK_LCA, 10'd1023, 1'b0}},
			'{make_word(KIND_LCA, 0, 0, 0, 0, 0, 0), 1'b1, '{RK_LCA, 10'd0, 1'b0}},
			'{make_word(KIND_ANC, 0, 0, 0, 0, 0, 1023), 1'b1, none_ans},
			'{make_word(KIND_LOAD, 1023, 1023, 0, 0, 1023, 1023), 1'b0, done_ans},
			'{make_word(KIND_BUILD, 1023, 1023, 1023, 1, 1023, 1023), 1'b1, done_ans},
			'{make_word(KIND_LCA, 1023, 5, 0, 0, 0, 0), 1'b0, done_ans},
			'{make_word(KIND_ANC, 5, 0, 0, 0, 0, 3), 1'b0, done_ans},
			'{make_word(KIND_LOAD, 1023, 0, 0, 0, 1, 0), 1'b0, done_ans},
			'{make_word(KIND_BUILD, 0, 0, 0, 0, 0, 0), 1'b1, done_ans},
			'{make_word(KIND_LCA, 1023, 0, 0, 0, 0, 0), 1'b1, '{RK_LCA, 10'd0, 1'b0}},
			'{make_word(KIND_LCA, 0, 1023, 0, 0, 0, 0), 1'b1, '{RK_LCA, 10'd0, 1'b0}},
			'{make_word(KIND_ANC, 1023, 0, 0, 0, 0, 1), 1'b1, '{RK_ANC, 10'd0, 1'b0}}
		};
		node_limit = 11'd1024;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One tree rooted at node 0 over all nodes defines every table entry.
		forest_depth[0] = 10'd0;
		send_word(make_word(KIND_LOAD, 0, 0, 0, 1, 0, 0));
		for (int i = 1; i < MAX_NODES; i++) begin
			a = $urandom_range(i - 1);
			forest_depth[i] = forest_depth[a] + 10'd1;
			send_word(make_word(KIND_LOAD, i, 0, a, 0, forest_depth[i], 0));
		end
		send_word(make_word(KIND_BUILD, 0, 0, 0, 0, 0, 0));

		foreach (dir_rows[r])
			send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].ans);

		phase = 0;
		rand_count = 0;
		while (rand_count < RAND_ITEMS) begin
			if (rand_count < 150) begin
				src_idle = 32; dst_idle = 65;
			end else if (rand_count < 300) begin
				src_idle = 65; dst_idle = 32;
			end else begin
				src_idle = 0; dst_idle = 0;
			end
			case (phase)
				0: count_sel = 11'd1;
				1: count_sel = 11'd0;
				2: count_sel = 11'd2047;
				3: count_sel = 11'd1024;
				default: count_sel = 11'($urandom_range(2, 48));
			endcase
			write_node_count(count_sel);
			span = (count_sel > 40) ? 16 : count_sel;
			if (span == 0) span = 1;
			load_forest(span);
			rand_count += span;
			send_word(make_word(KIND_BUILD, $urandom_range(1023), $urandom_range(1023),
				$urandom_range(1023), $urandom_range(1), $urandom_range(1023),
				$urandom_range(1023)));
			rand_count++;
			if (phase == 5) hold_req = 1;
			repeat ($urandom_range(10, 30)) begin
				tree_word_t q;
				q = make_word($urandom_range(1) ? KIND_LCA : KIND_ANC,
					$urandom_range(99) < 70 ? $urandom_range(span - 1) : $urandom_range(1023),
					$urandom_range(99) < 70 ? $urandom_range(span - 1) : $urandom_range(1023),
					$urandom_range(1023), $urandom_range(1), $urandom_range(1023),
					$urandom_range(1) ? $urandom_range(12) : $urandom_range(1023));
				// Noise load among the queries, kept inside the loaded forest.
				if ($urandom_range(99) < 5) begin
					q.kind = KIND_LOAD;
					q.node = 10'($urandom_range(span - 1));
				end
				send_word(q);
				rand_count++;
			end
			phase++;
		end

		drain(200);
		$display("Covered %0d input words and %0d answer words over %0d random phases,",
			words_sent, answers_seen, phase);
		$display("node counts 0, 1, 1024, 2047 and random, with a 3000-cycle output hold-off.");
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/tlca_pkg.sv
rtl/core/tlca_mem.sv
rtl/core/tree_lca_binary_lifting_top.sv
test/tb_tree_lca_binary_lifting_top.sv
